>>> hdl/rle_blit_pkg.sv
// Shared types and constants of the RLE sprite blitter.
`default_nettype none
package rle_blit_pkg;
    localparam int DEF_MAX_WIDTH = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_SCALE_FRAC_BITS = 8;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_SPRITE_SIZE = 3'd2;
    localparam logic [2:0] REG_SCALE = 3'd3;
    localparam logic [2:0] REG_SHEAR = 3'd4;
    localparam logic [2:0] REG_MIRROR = 3'd5;
    localparam logic [2:0] REG_KEYS = 3'd6;
    localparam logic [2:0] REG_TARGETS = 3'd7;

    localparam logic [14:0] RUN_MASK = 15'h7FFF;
    localparam int SKIP_BIT = 15;

    typedef struct packed {
        logic start;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dp_status_t;
endpackage
`default_nettype wire

>>> hdl/rle_blit_div.sv
// Restoring divider for unsigned operands, one quotient bit per cycle.
`default_nettype none
module rle_blit_div
    import rle_blit_pkg::*;
#(
    parameter int NW = 20,
    parameter int DW = 11
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire dp_cmd_t       cmd,
    input  wire logic [NW-1:0] numer,
    input  wire logic [DW-1:0] denom,
    output dp_status_t         status,
    output logic      [NW-1:0] quot,
    output logic      [DW-1:0] remd
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg, q_next;
    logic [DW-1:0] r_reg, r_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [DW:0]   trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg, q_reg[NW-1]};
        if (cmd.start) begin
            q_next = numer;
            r_next = '0;
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next = {q_reg[NW-2:0], 1'b0};
            if (trial >= {1'b0, denom}) begin
                r_next = DW'(trial - {1'b0, denom});
                q_next[0] = 1'b1;
            end else begin
                r_next = DW'(trial);
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (!aresetn) begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quot = q_reg;
    assign remd = r_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;
endmodule
`default_nettype wire

>>> hdl/rle_blit_ctrl.sv
// Controller: stream parsing, run state and sequencing of the pixel datapath.
`default_nettype none
module rle_blit_ctrl
    import rle_blit_pkg::*;
#(
    parameter int IW = 17
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_fire,
    input  wire logic [15:0]   word,
    input  wire logic          last,
    input  wire logic [IW-1:0] total,
    input  wire logic          scale_zero,
    input  wire dp_status_t    dp_st,
    input  wire logic          out_free,
    output logic               in_ready,
    output dp_cmd_t            dp_cmd,
    output logic [IW-1:0]      pix_idx,
    output logic               emit
);
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [14:0]   left_reg, left_next;
    logic [IW:0]   sum;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        left_next = left_reg;
        dp_cmd.start = 1'b0;
        emit = 1'b0;
        sum = {1'b0, idx_reg} + (IW+1)'(word[14:0]);
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (left_reg != '0) begin
                        left_next = left_reg - 1'b1;
                        if (idx_reg < total) begin
                            idx_next = idx_reg + 1'b1;
                            if (!scale_zero) begin
                                dp_cmd.start = 1'b1;
                                state_next = ST_CALC;
                            end
                        end
                    end else if ((word[14:0] & RUN_MASK) != '0) begin
                        if (word[SKIP_BIT]) begin
                            if (idx_reg < total)
                                idx_next = (sum > {1'b0, total}) ? total : IW'(sum);
                        end else begin
                            left_next = word[14:0];
                        end
                    end
                    if (last) begin
                        idx_next = '0;
                        left_next = '0;
                    end
                end
            end
            ST_CALC: begin
                if (dp_st.done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            left_reg <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            left_reg <= left_next;
        end
    end

    // The divider samples the index only in the cycle that starts it.
    assign pix_idx = idx_reg;

`ifndef NO_ASSERTIONS
    a_emit_state: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> state_reg == ST_EMIT) else $error("emit outside emit state");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.start |-> in_fire && left_reg != '0) else $error("start without literal");
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.start |-> idx_reg < total) else $error("pixel past total");
`endif
endmodule
`default_nettype wire

>>> hdl/rle_blit_dp.sv
// Datapath: color keys, column and row split, shear divide and scaling.
`default_nettype none
module rle_blit_dp
    import rle_blit_pkg::*;
#(
    parameter int IW = 17,
    parameter int WW = 9,
    parameter int HW = 9,
    parameter int FB = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire dp_cmd_t       cmd,
    input  wire logic [IW-1:0] pix_idx,
    input  wire logic [15:0]   word,
    input  wire logic [WW-1:0] w,
    input  wire logic [HW-1:0] h,
    input  wire logic signed [10:0] org_x,
    input  wire logic signed [10:0] org_y,
    input  wire logic [10:0]   scale,
    input  wire logic signed [8:0] shear,
    input  wire logic          mirror,
    input  wire logic [47:0]   keys,
    input  wire logic [47:0]   targets,
    output dp_status_t         status,
    output logic [12:0]        rx,
    output logic [12:0]        ry,
    output logic [3:0]         side,
    output logic [15:0]        color
);
    localparam int NW = HW + 9;
    typedef enum logic [2:0] {
        P_IDLE = 3'b001,
        P_DIV1 = 3'b010,
        P_DIV2 = 3'b100
    } phase_t;

    phase_t         ph_reg, ph_next;
    dp_cmd_t        c1, c2;
    dp_status_t     s1, s2;
    logic [IW-1:0]  q1;
    logic [WW-1:0]  r1;
    logic [NW-1:0]  q2, num2;
    logic [HW-1:0]  r2, den2;
    logic [15:0]    color_reg, color_next;
    logic [WW-1:0]  col;
    logic [HW-1:0]  row, row_reg;
    logic           neg;
    logic [8:0]     shabs;
    logic [NW-1:0]  shq;
    logic signed [NW+1:0] shv;
    logic [WW+11:0] cx;
    logic [HW+11:0] cy;
    logic [12:0]    rx_reg, ry_reg;
    logic [FB+3:0]  sd;
    logic           done_reg;

    rle_blit_div #(.NW(IW), .DW(WW)) u_div_col (
        .aclk, .aresetn, .cmd(c1), .numer(pix_idx), .denom(w),
        .status(s1), .quot(q1), .remd(r1));
    rle_blit_div #(.NW(NW), .DW(HW)) u_div_shear (
        .aclk, .aresetn, .cmd(c2), .numer(num2), .denom(den2),
        .status(s2), .quot(q2), .remd(r2));

    always_comb begin
        color_next = word;
        if (word == keys[15:0]) color_next = targets[15:0];
        else if (word == keys[31:16]) color_next = targets[31:16];
        else if (word == keys[47:32]) color_next = targets[47:32];
    end

    assign row = HW'(q1);
    assign col = mirror ? WW'(w - 1'b1 - r1) : r1;
    assign neg = shear[8];
    assign shabs = neg ? 9'(-shear) : shear;
    assign num2 = NW'(h - 1'b1 - row) * NW'(shabs);
    assign den2 = (h > HW'(1)) ? HW'(h - 1'b1) : HW'(1);
    // Sign-magnitude divide gives truncation toward zero.
    assign shq = q2;
    assign shv = neg ? -$signed({2'b00, shq}) : $signed({2'b00, shq});
    assign cx = ((WW+12)'(col) * (WW+12)'(scale)) >> FB;
    assign cy = ((HW+12)'(row_reg) * (HW+12)'(scale)) >> FB;
    assign sd = (FB+4)'((scale + (12'd1 << FB) - 1'b1) >> FB);

    always_comb begin
        ph_next = ph_reg;
        c1.start = 1'b0;
        c2.start = 1'b0;
        case (ph_reg)
            P_IDLE: if (cmd.start) begin
                c1.start = 1'b1;
                ph_next = P_DIV1;
            end
            P_DIV1: if (s1.done) begin
                c2.start = 1'b1;
                ph_next = P_DIV2;
            end
            P_DIV2: if (s2.done) ph_next = P_IDLE;
            default: ph_next = P_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) color_reg <= color_next;
        if (s1.done) row_reg <= row;
        if (s1.done) rx_reg <= 13'(cx);
        if (s2.done) begin
            rx <= 13'(rx_reg + 13'(org_x) + 13'(shv));
            ry <= 13'(13'(cy) + 13'(org_y));
        end
        if (!aresetn) begin
            ph_reg <= P_IDLE;
            done_reg <= 1'b0;
        end else begin
            ph_reg <= ph_next;
            done_reg <= s2.done;
        end
    end

    assign color = color_reg;
    assign side = (scale <= (11'd1 << FB)) ? 4'd1 : (sd > 15 ? 4'd15 : 4'(sd));
    assign status.busy = (ph_reg != P_IDLE);
    assign status.done = done_reg;
endmodule
`default_nettype wire

>>> hdl/rle_sprite_keyed_scaled_shear_blit.sv
// Top level of the keyed, mirrored, sheared and scaled RLE sprite blitter.
// Tokens and pixels outside the sprite are accepted at one item per cycle.
// A drawn pixel passes through two bit-serial dividers in turn (column split, then
// shear divide), then waits in the emit state until the result register is free.
// One item is in flight at a time; a stalled result output holds back the next item.
// Reset (synchronous, active low) clears position, run count and registers to defaults.
`default_nettype none
module rle_sprite_keyed_scaled_shear_blit
    import rle_blit_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int SCALE_FRAC_BITS = DEF_SCALE_FRAC_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // stream_word
    input  wire logic        s_tlast,   // last_word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // rect_x, rect_y, rect_side, pixel_color, zero pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int IW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    logic signed [10:0] ox_reg, oy_reg;
    logic [24:0] size_reg;
    logic [10:0] scale_reg;
    logic signed [8:0] shear_reg;
    logic        mirror_reg;
    logic [47:0] keys_reg, targets_reg;
    logic [WW-1:0] w;
    logic [HW-1:0] h;
    logic [IW-1:0] total, pix_idx;
    dp_cmd_t     dp_cmd;
    dp_status_t  dp_st;
    logic        emit, in_fire, mv_reg;
    logic [12:0] rx, ry;
    logic [3:0]  side;
    logic [15:0] color;
    logic [47:0] md_reg;

    // Registers change only between items, never under a pixel in progress.
    assign cfg_ready = s_tready && !s_tvalid;
    assign w = (size_reg[15:0] > 16'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(size_reg[15:0]);
    assign h = ({7'd0, size_reg[24:16]} > 16'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
                                                            : HW'(size_reg[24:16]);
    assign total = IW'(w) * IW'(h);
    assign in_fire = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ox_reg <= '0; oy_reg <= '0; size_reg <= 25'h10001;
            scale_reg <= 11'(1 << SCALE_FRAC_BITS); shear_reg <= '0; mirror_reg <= 1'b0;
            keys_reg <= '0; targets_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ORIGIN_X: ox_reg <= cfg_data[10:0];
                REG_ORIGIN_Y: oy_reg <= cfg_data[10:0];
                REG_SPRITE_SIZE: size_reg <= cfg_data[24:0];
                REG_SCALE: scale_reg <= cfg_data[10:0];
                REG_SHEAR: shear_reg <= cfg_data[8:0];
                REG_MIRROR: mirror_reg <= cfg_data[0];
                REG_KEYS: keys_reg <= cfg_data;
                REG_TARGETS: targets_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    rle_blit_ctrl #(.IW(IW)) u_ctrl (
        .aclk, .aresetn, .in_fire, .word(s_tdata), .last(s_tlast), .total,
        .scale_zero(scale_reg == '0), .dp_st, .out_free(!mv_reg || m_tready),
        .in_ready(s_tready), .dp_cmd, .pix_idx, .emit);

    rle_blit_dp #(.IW(IW), .WW(WW), .HW(HW), .FB(SCALE_FRAC_BITS)) u_dp (
        .aclk, .aresetn, .cmd(dp_cmd), .pix_idx, .word(s_tdata), .w, .h,
        .org_x(ox_reg), .org_y(oy_reg), .scale(scale_reg), .shear(shear_reg),
        .mirror(mirror_reg), .keys(keys_reg), .targets(targets_reg),
        .status(dp_st), .rx, .ry, .side, .color);

    always_ff @(posedge aclk) begin
        if (emit) md_reg <= {2'b00, color, side, ry, rx};
        if (!aresetn) mv_reg <= 1'b0;
        else if (emit) mv_reg <= 1'b1;
        else if (m_tready) mv_reg <= 1'b0;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata = md_reg;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> !mv_reg || m_tready) else $error("result overwritten");
    a_side_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[29:26] != 4'd0) else $error("zero side");
    a_busy_block: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_st.busy |-> !s_tready) else $error("input taken while busy");
`endif
endmodule
`default_nettype wire
